// ----- rtl/core/rlcf_pkg.sv -----
package rlcf_pkg;

  // History ring size in address bits (supported range 4 to 24)
  localparam int HIST_BITS   = 16;
  localparam int HIST_DEPTH  = 1 << HIST_BITS;
  localparam int POS_ROWS    = 256;
  localparam int POS_TAPS    = 4;
  localparam int POS_ROW_W   = POS_TAPS * HIST_BITS;

  // Remainder unit retires two quotient bits per cycle
  localparam int DIV_ITER    = (HIST_BITS + 1) / 2;
  localparam int DIV_W       = 2 * DIV_ITER;
  localparam int DIV_CNT_W   = $clog2(DIV_ITER + 1);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 224;

  typedef logic [HIST_BITS-1:0] hist_addr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RD_N,
    ST_RD_NN,
    ST_RD_NW,
    ST_DIV_WAIT,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    SEL_N,
    SEL_NN,
    SEL_NW
  } hist_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      update;
    logic      div_start;
    logic      hist_rd;
    hist_sel_t sel;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

endpackage

// ----- rtl/core/record_length_context_former_core.sv -----
// channel | dir | tdata fields (lowest bit up)
// in_     | in  | data_byte[7:0]
// out_    | out | record_length[15:0], column[15:0], ctx_byte_above, ctx_above_two_up,
//         |     | ctx_above_upleft, ctx_byte_column, ctx_above_column, ctx_length_column
//
// The column remainder unit, two bits per cycle, sets how long one item takes, with
// history reads on one port alongside.
// Reset clears the position valid bits, write position and ring fill flag; no sweep.
// History entries not yet written read as zero by the fill tracking.
// A result waits in the output register; the next item is accepted meanwhile and its
// result holds in the final step until the register frees.
module record_length_context_former_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rlcf_pkg::IN_TDATA_W-1:0]  in_tdata,   // data_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rlcf_pkg::OUT_TDATA_W-1:0] out_tdata   // record_length, column, six ctx words
);
  import rlcf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rlcf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rlcf_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule

// ----- rtl/core/rlcf_ctrl.sv -----
module rlcf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rlcf_pkg::dp_cmd_t cmd,
  input  rlcf_pkg::dp_sts_t sts
);
  import rlcf_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = ST_RD_N;
      ST_RD_N:     state_nxt = ST_RD_NN;
      ST_RD_NN:    state_nxt = ST_RD_NW;
      ST_RD_NW:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (!sts.div_busy) state_nxt = ST_FINISH;
      ST_FINISH:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.sel = SEL_N;
    unique case (state_r)
      ST_IDLE:     cmd.load_in = in_tvalid;
      ST_UPDATE:   cmd.update = 1'b1;
      ST_RD_N: begin
        cmd.hist_rd   = 1'b1;
        cmd.sel       = SEL_N;
        cmd.div_start = 1'b1;
      end
      ST_RD_NN: begin
        cmd.hist_rd = 1'b1;
        cmd.sel     = SEL_NN;
      end
      ST_RD_NW: begin
        cmd.hist_rd = 1'b1;
        cmd.sel     = SEL_NW;
      end
      ST_DIV_WAIT: ;
      ST_FINISH:   cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/rlcf_divider.sv -----
module rlcf_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rlcf_pkg::hist_addr_t dividend,
  input  rlcf_pkg::hist_addr_t divisor,
  output logic                 busy,
  output rlcf_pkg::hist_addr_t remainder
);
  import rlcf_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     dvd_r;
  hist_addr_t           rem_r;
  hist_addr_t           rem_mid, rem_end;
  logic [HIST_BITS:0]   t0, t1;

  // two restoring steps per cycle, dividend MSB first
  always_comb begin
    t0 = {rem_r, dvd_r[DIV_W-1]};
    if (t0 >= {1'b0, divisor}) t0 = t0 - {1'b0, divisor};
    rem_mid = t0[HIST_BITS-1:0];
    t1 = {rem_mid, dvd_r[DIV_W-2]};
    if (t1 >= {1'b0, divisor}) t1 = t1 - {1'b0, divisor};
    rem_end = t1[HIST_BITS-1:0];
  end

  assign busy      = (cnt_r != '0);
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_ITER);
    end else if (busy) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= DIV_W'(dividend);
    end else if (busy) begin
      rem_r <= rem_end;
      dvd_r <= {dvd_r[DIV_W-3:0], 2'b00};
    end
  end

endmodule

// ----- rtl/core/rlcf_datapath.sv -----
module rlcf_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [rlcf_pkg::IN_TDATA_W-1:0]    in_byte,
  input  rlcf_pkg::dp_cmd_t                  cmd,
  output rlcf_pkg::dp_sts_t                  sts,
  output logic [rlcf_pkg::OUT_TDATA_W-1:0]   out_data
);
  import rlcf_pkg::*;

  logic [7:0]           hist_mem [HIST_DEPTH];
  logic [POS_ROW_W-1:0] pos_mem  [POS_ROWS];
  logic [POS_ROWS-1:0]  pos_vld_r;

  hist_addr_t           p_r;
  logic                 wrapped_r;
  hist_addr_t           len_r, len_nxt;
  logic [7:0]           b_r;
  logic [POS_ROW_W-1:0] pos_row_r;
  logic                 row_vld_r;
  hist_addr_t           pos [POS_TAPS];
  hist_addr_t           g0, g1, g2, g3;

  hist_addr_t           rd_addr;
  logic                 addr_ok;
  logic [7:0]           hist_q_r;
  hist_sel_t            sel_r;
  logic                 addr_ok_r;
  logic                 rd_vld_r;
  logic [7:0]           n_r, nn_r, nw_r;

  hist_addr_t           rem;
  logic                 div_busy;
  logic [31:0]          b32, n32, nn32, nw32, len32, col32;
  logic [OUT_TDATA_W-1:0] out_data_r;

  rlcf_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (p_r),
    .divisor   (len_r),
    .busy      (div_busy),
    .remainder (rem)
  );

  assign sts.div_busy = div_busy;

  // unpack last positions, untouched rows read as zero
  always_comb begin
    for (int k = 0; k < POS_TAPS; k++) begin
      pos[k] = row_vld_r ? pos_row_r[k*HIST_BITS +: HIST_BITS] : '0;
    end
    g3 = pos[2] - pos[3];
    g2 = pos[1] - pos[2];
    g1 = pos[0] - pos[1];
    g0 = p_r - pos[0];
    len_nxt = len_r;
    if (g3 == g2 && g2 == g1 && g1 == g0 && g0 > hist_addr_t'(3)) len_nxt = g0;
  end

  always_comb begin
    case (cmd.sel)
      SEL_N:   rd_addr = p_r - len_r;
      SEL_NN:  rd_addr = p_r - {len_r[HIST_BITS-2:0], 1'b0};
      SEL_NW:  rd_addr = p_r - len_r - hist_addr_t'(1);
      default: rd_addr = p_r - len_r;
    endcase
    // ring fills in order, so until it wraps only addresses below the write position are written
    addr_ok = wrapped_r || (rd_addr < p_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r       <= '0;
      wrapped_r <= 1'b0;
      len_r     <= hist_addr_t'(1);
      pos_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cmd.update) begin
        p_r              <= p_r + hist_addr_t'(1);
        len_r            <= len_nxt;
        pos_vld_r[b_r]   <= 1'b1;
        if (&p_r) wrapped_r <= 1'b1;
      end
      rd_vld_r <= cmd.hist_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      b_r       <= in_byte;
      pos_row_r <= pos_mem[in_byte];
      row_vld_r <= pos_vld_r[in_byte];
    end
    if (cmd.update) begin
      pos_mem[b_r] <= {pos[2], pos[1], pos[0], p_r};
      hist_mem[p_r] <= b_r;
    end
    if (cmd.hist_rd) begin
      hist_q_r  <= hist_mem[rd_addr];
      sel_r     <= cmd.sel;
      addr_ok_r <= addr_ok;
    end
    if (rd_vld_r) begin
      case (sel_r)
        SEL_N:   n_r  <= addr_ok_r ? hist_q_r : 8'd0;
        SEL_NN:  nn_r <= addr_ok_r ? hist_q_r : 8'd0;
        SEL_NW:  nw_r <= addr_ok_r ? hist_q_r : 8'd0;
        default: ;
      endcase
    end
    if (cmd.load_out) out_data_r <= {
      len32 + (col32 << 12),
      n32 + (len32 << 8) + (col32 << 20),
      b32 + (len32 << 8) + (col32 << 20),
      n32 + (nw32 << 8) + (len32 << 16),
      n32 + (nn32 << 8) + (len32 << 16),
      b32 + (n32 << 8) + (len32 << 16),
      col32[15:0],
      len32[15:0]
    };
  end

  assign b32   = 32'(b_r);
  assign n32   = 32'(n_r);
  assign nn32  = 32'(nn_r);
  assign nw32  = 32'(nw_r);
  assign len32 = 32'(len_r);
  assign col32 = 32'(rem);

  assign out_data = out_data_r;

endmodule
